FILE: hw/rtl/rss_pkg.sv
// rss_pkg: widths, codes and the controller/datapath interface types
// of the running sample statistics unit
// no dependencies
`default_nettype none

package rss_pkg;

    // sizing of the arithmetic
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;

    localparam int WORD_W  = 32;                    // sample and count fields
    localparam int SUM_W   = 64;                    // running sums
    localparam int SCALE_W = 16;                    // scale register
    localparam int OUT_W   = 48;                    // scaled result fields
    localparam int MDIV_W  = WORD_W + SCALE_W;      // count times scale
    localparam int DIV_W   = SUM_W + FRAC_BITS;     // widest dividend
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DIFF_W  = WORD_W + SUM_W;        // variance numerator
    localparam int RAD_W   = DIFF_W + 2 * FRAC_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SQ_CNT_W = $clog2(ROOT_W);
    localparam int ACC_W   = 2 * SUM_W + 2;         // signed accumulator
    localparam int PROD_W  = 2 * WORD_W;

    localparam logic [WORD_W-1:0] SAMPLE_MASK =
        WORD_W'((65'd1 << SAMPLE_BITS) - 65'd1);

    // item command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OVF = 1'b1;

    // register index
    localparam logic REG_SCALE = 1'b0;

    // multiply terms of a report
    localparam logic [2:0] TERM_SCALE  = 3'd0;   // count * scale
    localparam logic [2:0] TERM_NSQ_LO = 3'd1;   // count * square sum low
    localparam logic [2:0] TERM_NSQ_HI = 3'd2;   // count * square sum high
    localparam logic [2:0] TERM_SUM_LL = 3'd3;   // sum low squared
    localparam logic [2:0] TERM_SUM_LH = 3'd4;   // sum low * sum high, twice
    localparam logic [2:0] TERM_SUM_HH = 3'd5;   // sum high squared

    // divide jobs of a report
    localparam logic [1:0] JOB_MIN  = 2'd0;
    localparam logic [1:0] JOB_MAX  = 2'd1;
    localparam logic [1:0] JOB_MEAN = 2'd2;
    localparam logic [1:0] JOB_STD  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       add_mul;
        logic       add_upd;
        logic       rpt_mul;
        logic       rpt_acc;
        logic [2:0] term;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       div_load;
        logic       div_step;
        logic [1:0] job;
        logic       finish;
    } rss_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sqrt_last;
        logic div_last;
        logic out_busy;
    } rss_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/running_sample_statistics_unit.sv
// running_sample_statistics_unit: top level of the statistics unit
// depends on rss_pkg, rss_ctrl and rss_datapath
//
// Usage: items enter on cmd_valid/cmd_stall with command and sample; an add
// item (command 0) counts the sample into the count, sum, square sum, min
// and max; a report item (command 1) returns count and the scaled min, max,
// mean and standard deviation. Each item gives one result on
// res_valid/res_stall. The scale divisor is written over the APB port.
// An add item passes a multiply state and an update state; its result is
// loaded in the update state once the result register is free and is
// offered from the cycle after. A report runs six multiply and accumulate
// terms on the one 32x32 multiplier, then the bit-pair square root and
// four jobs in the bit-serial divider before its result is loaded. One
// item is worked at a time: the next is taken the cycle after the result
// is loaded.
// Reset clears all statistics and the result valid flag and sets scale to 1.
// If the receiver stalls, the finished result holds in the output register
// and the unit waits before loading the next result; the input stays
// stalled while an item is at work.
`default_nettype none

module running_sample_statistics_unit
    import rss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire logic               command,
    input  wire logic [WORD_W-1:0]  sample,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic                    status,
    output logic [WORD_W-1:0]       count,
    output logic [OUT_W-1:0]        min_scaled,
    output logic [OUT_W-1:0]        max_scaled,
    output logic [OUT_W-1:0]        mean_scaled,
    output logic [OUT_W-1:0]        std_dev_scaled,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    rss_cmd_t           ctl;
    rss_stat_t          stat;
    logic               cfg_we;
    logic [SCALE_W-1:0] scale;

    // register port decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SCALE);
    assign prdata = (paddr[2] == REG_SCALE) ? 32'(scale) : 32'd0;

    rss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .stat      (stat),
        .ctl       (ctl)
    );

    rss_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .sample         (sample),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[SCALE_W-1:0]),
        .scale          (scale),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .status         (status),
        .count          (count),
        .min_scaled     (min_scaled),
        .max_scaled     (max_scaled),
        .mean_scaled    (mean_scaled),
        .std_dev_scaled (std_dev_scaled)
    );

    // a taken item keeps the input stalled while it is worked
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("input not stalled after an item was taken");

    // an add into a free result register is offered after the multiply and update states
    a_add_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (command == CMD_ADD) && !res_valid) |-> ##3 res_valid)
        else $error("add result not shown in time");

    // an overflow result carries no statistics
    a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status == STATUS_OVF)) |-> ((count == '0) && (mean_scaled == '0)))
        else $error("overflow result carries statistics");

endmodule

`default_nettype wire

FILE: hw/rtl/rss_ctrl.sv
// rss_ctrl: sequencing state machine of the running sample statistics unit
// depends on rss_pkg
`default_nettype none

module rss_ctrl
    import rss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire logic      command,
    input  wire rss_stat_t stat,
    output rss_cmd_t       ctl
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_ADD_MUL   = 10'b0000000010,
        S_ADD_UPD   = 10'b0000000100,
        S_RPT_MUL   = 10'b0000001000,
        S_RPT_ACC   = 10'b0000010000,
        S_SQRT_LOAD = 10'b0000100000,
        S_SQRT_RUN  = 10'b0001000000,
        S_DIV_LOAD  = 10'b0010000000,
        S_DIV_RUN   = 10'b0100000000,
        S_FINISH    = 10'b1000000000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic [2:0] term_reg, term_next;
    logic [1:0] job_reg, job_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= TERM_SCALE;
            job_reg   <= JOB_MIN;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            job_reg   <= job_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        job_next   = job_reg;
        ctl        = '0;
        ctl.term   = term_reg;
        ctl.job    = job_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load  = 1'b1;
                    term_next = TERM_SCALE;
                    job_next  = JOB_MIN;
                    state_next = (command == CMD_REPORT) ? S_RPT_MUL : S_ADD_MUL;
                end
            end
            S_ADD_MUL:
            begin
                ctl.add_mul = 1'b1;
                state_next  = S_ADD_UPD;
            end
            S_ADD_UPD:
            begin
                if (!stat.out_busy)
                begin
                    ctl.add_upd = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_RPT_MUL:
            begin
                ctl.rpt_mul = 1'b1;
                state_next  = S_RPT_ACC;
            end
            S_RPT_ACC:
            begin
                ctl.rpt_acc = 1'b1;
                if (term_reg == TERM_SUM_HH)
                begin
                    state_next = S_SQRT_LOAD;
                end
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = S_RPT_MUL;
                end
            end
            S_SQRT_LOAD:
            begin
                ctl.sqrt_load = 1'b1;
                state_next    = S_SQRT_RUN;
            end
            S_SQRT_RUN:
            begin
                ctl.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                begin
                    state_next = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                ctl.div_load = 1'b1;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    if (job_reg == JOB_STD)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        job_next   = job_reg + 2'd1;
                        state_next = S_DIV_LOAD;
                    end
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rss_datapath.sv
// rss_datapath: accumulators, shared multiplier, square root and divide
// units, scale register and result register of the statistics unit
// depends on rss_pkg
`default_nettype none

module rss_datapath
    import rss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rss_cmd_t           ctl,
    output rss_stat_t               stat,
    input  wire logic [WORD_W-1:0]  sample,
    input  wire logic               cfg_we,
    input  wire logic [SCALE_W-1:0] cfg_wdata,
    output logic [SCALE_W-1:0]      scale,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic                    status,
    output logic [WORD_W-1:0]       count,
    output logic [OUT_W-1:0]        min_scaled,
    output logic [OUT_W-1:0]        max_scaled,
    output logic [OUT_W-1:0]        mean_scaled,
    output logic [OUT_W-1:0]        std_dev_scaled
);

    // statistics state
    logic [WORD_W-1:0]  count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sq_reg;
    logic [WORD_W-1:0]  largest_reg;
    logic [WORD_W-1:0]  smallest_reg;
    logic [SCALE_W-1:0] scale_reg;

    // working registers
    logic [WORD_W-1:0]  smp_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [MDIV_W-1:0]  m_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+1:0]   srem_reg;
    logic [SQ_CNT_W-1:0] scnt_reg;

    logic [DIV_W-1:0]     dvd_reg;
    logic [MDIV_W-1:0]    drem_reg;
    logic [MDIV_W-1:0]    dsor_reg;
    logic [OUT_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [OUT_W-1:0]     res_q [4];

    // result register
    logic              res_valid_reg;
    logic              status_reg;
    logic [WORD_W-1:0] count_out_reg;
    logic [OUT_W-1:0]  min_out_reg;
    logic [OUT_W-1:0]  max_out_reg;
    logic [OUT_W-1:0]  mean_out_reg;
    logic [OUT_W-1:0]  std_out_reg;

    logic [SCALE_W-1:0] sc_eff;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [SUM_W:0]     nsum;
    logic [SUM_W:0]     nsq;
    logic               ovf;
    logic [ACC_W-1:0]   term_val;
    logic               term_neg;
    logic [ACC_W-1:0]   acc_next;
    logic [DIFF_W-1:0]  diff;
    logic [ROOT_W+3:0]  sq_sh;
    logic [ROOT_W+3:0]  sq_trial;
    logic               sq_ge;
    logic [MDIV_W:0]    dv_sh;
    logic               dv_ge;
    logic [OUT_W-1:0]   quo_next;

    // a zero scale acts as one
    assign sc_eff = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    assign scale  = scale_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (ctl.add_mul)
        begin
            mul_a = smp_reg;
            mul_b = smp_reg;
        end
        else
        begin
            case (ctl.term)
                TERM_SCALE:
                begin
                    mul_a = count_reg;
                    mul_b = WORD_W'(sc_eff);
                end
                TERM_NSQ_LO:
                begin
                    mul_a = count_reg;
                    mul_b = sq_reg[WORD_W-1:0];
                end
                TERM_NSQ_HI:
                begin
                    mul_a = count_reg;
                    mul_b = sq_reg[SUM_W-1:WORD_W];
                end
                TERM_SUM_LL:
                begin
                    mul_a = sum_reg[WORD_W-1:0];
                    mul_b = sum_reg[WORD_W-1:0];
                end
                TERM_SUM_LH:
                begin
                    mul_a = sum_reg[WORD_W-1:0];
                    mul_b = sum_reg[SUM_W-1:WORD_W];
                end
                TERM_SUM_HH:
                begin
                    mul_a = sum_reg[SUM_W-1:WORD_W];
                    mul_b = sum_reg[SUM_W-1:WORD_W];
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // add: new sums and wrap detection
    assign nsum = {1'b0, sum_reg} + (SUM_W + 1)'(smp_reg);
    assign nsq  = {1'b0, sq_reg} + {1'b0, prod_reg};
    assign ovf  = (count_reg == '1) || nsum[SUM_W] || nsq[SUM_W];

    // variance numerator: weighted partial products into a signed sum
    always_comb
    begin
        term_val = ACC_W'(prod_reg);
        term_neg = 1'b0;
        case (ctl.term)
            TERM_NSQ_HI: term_val = ACC_W'(prod_reg) << WORD_W;
            TERM_SUM_LL: term_neg = 1'b1;
            TERM_SUM_LH:
            begin
                term_val = ACC_W'(prod_reg) << (WORD_W + 1);
                term_neg = 1'b1;
            end
            TERM_SUM_HH:
            begin
                term_val = ACC_W'(prod_reg) << (2 * WORD_W);
                term_neg = 1'b1;
            end
            default:
            begin
                term_val = ACC_W'(prod_reg);
                term_neg = 1'b0;
            end
        endcase
        acc_next = term_neg ? (acc_reg - term_val) : (acc_reg + term_val);
    end

    // negative or zero variance clamps to zero
    assign diff = (!acc_reg[ACC_W-1] && (acc_reg != '0)) ? acc_reg[DIFF_W-1:0] : '0;

    // square root step: two radicand bits per cycle
    assign sq_sh    = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    // restoring divide step: one quotient bit per cycle
    assign dv_sh    = {drem_reg, dvd_reg[DIV_W-1]};
    assign dv_ge    = (dv_sh >= {1'b0, dsor_reg});
    assign quo_next = {quo_reg[OUT_W-2:0], dv_ge};

    assign stat.sqrt_last = (scnt_reg == '0);
    assign stat.div_last  = (dcnt_reg == '0);
    assign stat.out_busy  = res_valid_reg && res_stall;

    // statistics state and scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            largest_reg  <= '0;
            smallest_reg <= '0;
            scale_reg    <= SCALE_W'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
            if (ctl.add_upd)
            begin
                if (ovf)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    sq_reg    <= '0;
                end
                else
                begin
                    count_reg <= count_reg + WORD_W'(1);
                    sum_reg   <= nsum[SUM_W-1:0];
                    sq_reg    <= nsq[SUM_W-1:0];
                    if (smp_reg > largest_reg)
                    begin
                        largest_reg <= smp_reg;
                    end
                    // zero leaves an unset minimum unset
                    if ((smallest_reg == '0) || (smp_reg < smallest_reg))
                    begin
                        smallest_reg <= smp_reg;
                    end
                end
            end
        end
    end

    // multiplier, accumulator and scaled divisor
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            smp_reg <= sample & SAMPLE_MASK;
            acc_reg <= '0;
        end
        if (ctl.add_mul || ctl.rpt_mul)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctl.rpt_acc)
        begin
            if (ctl.term == TERM_SCALE)
            begin
                m_reg <= prod_reg[MDIV_W-1:0];
            end
            else
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // square root unit
    always_ff @(posedge clk)
    begin
        if (ctl.sqrt_load)
        begin
            rad_reg  <= RAD_W'(diff) << (2 * FRAC_BITS);
            root_reg <= '0;
            srem_reg <= '0;
            scnt_reg <= SQ_CNT_W'(ROOT_W - 1);
        end
        else if (ctl.sqrt_step)
        begin
            rad_reg  <= rad_reg << 2;
            scnt_reg <= scnt_reg - SQ_CNT_W'(1);
            if (sq_ge)
            begin
                srem_reg <= (ROOT_W + 2)'(sq_sh - sq_trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= sq_sh[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // divide unit, shared by all four scaled results
    always_ff @(posedge clk)
    begin
        if (ctl.div_load)
        begin
            drem_reg <= '0;
            quo_reg  <= '0;
            dcnt_reg <= DIV_CNT_W'(DIV_W - 1);
            case (ctl.job)
                JOB_MIN:
                begin
                    dvd_reg  <= DIV_W'(smallest_reg) << FRAC_BITS;
                    dsor_reg <= MDIV_W'(sc_eff);
                end
                JOB_MAX:
                begin
                    dvd_reg  <= DIV_W'(largest_reg) << FRAC_BITS;
                    dsor_reg <= MDIV_W'(sc_eff);
                end
                JOB_MEAN:
                begin
                    dvd_reg  <= DIV_W'(sum_reg) << FRAC_BITS;
                    dsor_reg <= m_reg;
                end
                default:
                begin
                    dvd_reg  <= DIV_W'(root_reg);
                    dsor_reg <= m_reg;
                end
            endcase
        end
        else if (ctl.div_step)
        begin
            dvd_reg  <= dvd_reg << 1;
            dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
            quo_reg  <= quo_next;
            if (dv_ge)
            begin
                drem_reg <= MDIV_W'(dv_sh - {1'b0, dsor_reg});
            end
            else
            begin
                drem_reg <= dv_sh[MDIV_W-1:0];
            end
            if (stat.div_last)
            begin
                res_q[ctl.job] <= quo_next;
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.add_upd || ctl.finish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (ctl.add_upd)
        begin
            status_reg    <= ovf ? STATUS_OVF : STATUS_OK;
            count_out_reg <= '0;
            min_out_reg   <= '0;
            max_out_reg   <= '0;
            mean_out_reg  <= '0;
            std_out_reg   <= '0;
        end
        else if (ctl.finish)
        begin
            status_reg    <= STATUS_OK;
            count_out_reg <= count_reg;
            min_out_reg   <= res_q[JOB_MIN];
            max_out_reg   <= res_q[JOB_MAX];
            // empty count reports zero mean and deviation
            mean_out_reg  <= (count_reg == '0) ? '0 : res_q[JOB_MEAN];
            std_out_reg   <= (count_reg == '0) ? '0 : res_q[JOB_STD];
        end
    end

    assign res_valid      = res_valid_reg;
    assign status         = status_reg;
    assign count          = count_out_reg;
    assign min_scaled     = min_out_reg;
    assign max_scaled     = max_out_reg;
    assign mean_scaled    = mean_out_reg;
    assign std_dev_scaled = std_out_reg;

endmodule

`default_nettype wire
